// ===== design/bdf_pkg.sv =====
// Shared types and constants of the beat-tracking forward pass.
// Used by bdf_regs and beat_dp_forward_pass; depends on nothing else.

package bdf_pkg;

    localparam int PEN_W       = 32;
    localparam int LOC_W       = 24;
    localparam int CUM_W       = 48;
    localparam int SUM_W       = 49;
    localparam int ACC_W       = 50;
    localparam int FIDX_W      = 16;
    localparam int LINK_W      = 17;
    localparam int TABLE_DEPTH = 256;
    localparam int TAB_AW      = 8;
    localparam int CNT_W       = 9;

    localparam logic [7:0] MIN_GAP_RESET  = 8'd1;
    localparam logic [8:0] NUM_GAPS_RESET = 9'd2;

    localparam logic REG_MIN_GAP  = 1'b0;
    localparam logic REG_NUM_GAPS = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_HI = {2'b00, 1'b0, {(CUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO = {2'b11, 1'b1, {(CUM_W-1){1'b0}}};
    localparam logic [CUM_W-1:0] CUM_HI = {1'b0, {(CUM_W-1){1'b1}}};
    localparam logic [CUM_W-1:0] CUM_LO = {1'b1, {(CUM_W-1){1'b0}}};

    typedef struct packed {
        logic [7:0] min_gap;
        logic [8:0] num_gaps;
    } bdf_cfg_t;

endpackage

// ===== design/bdf_regs.sv =====
// Configuration registers of the forward pass behind an APB-style port.
// Depends on bdf_pkg for the register codes and the configuration struct.

module bdf_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bdf_pkg::bdf_cfg_t cfg
);

    logic [7:0] min_gap_reg;
    logic [8:0] num_gaps_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg  <= bdf_pkg::MIN_GAP_RESET;
            num_gaps_reg <= bdf_pkg::NUM_GAPS_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                bdf_pkg::REG_MIN_GAP:  min_gap_reg  <= pwdata[7:0];
                bdf_pkg::REG_NUM_GAPS: num_gaps_reg <= pwdata[8:0];
                default:               min_gap_reg  <= min_gap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            bdf_pkg::REG_MIN_GAP:  prdata = {24'd0, min_gap_reg};
            bdf_pkg::REG_NUM_GAPS: prdata = {23'd0, num_gaps_reg};
            default:               prdata = '0;
        endcase
        prdata = prdata | {29'd0, paddr[1:0] & 2'b00, 1'b0};
    end

    assign cfg.min_gap  = min_gap_reg;
    assign cfg.num_gaps = num_gaps_reg;

endmodule

// ===== design/beat_dp_forward_pass.sv =====
// Forward pass of a beat-tracking dynamic program: penalty table, score ring, sequencer.
// Depends on bdf_pkg and bdf_regs.
//
// Usage. The item channel (item_valid/item_ready) takes two kinds of item. A load item
// (op = 0) writes penalty_value into the penalty table at penalty_index; it yields no
// result. A score item (op = 1) carries one frame's local_score and yields exactly one
// result on the result channel (result_valid/result_ready): the frame index, the
// saturated cumulative score and the back-link frame (all ones when none).
// A score item is swept in state RUN over cnt gaps, cnt being the clamped number of
// candidate gaps (at most 256): one gap per cycle passes the single read port of the
// penalty table and of the score ring into one shared adder and comparator. The last
// comparison is done in LAST and the result register is loaded in FINISH. item_ready is
// low while a frame is in progress, so a new item is taken only after FINISH is left.
// The result register parts the two sides: new items are taken while a result waits;
// a frame that finishes while the previous result is still unread holds until it is taken.
// The user must ensure registers are written over the APB-style port only while the
// block is idle; the block does not enforce this. Reset clears the sequencer, the frame
// count and the registers; the tables hold no reset value and need no clearing pass.

module beat_dp_forward_pass #(
    parameter int MAX_GAP    = 256,
    parameter int MAX_FRAMES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        op,
    input  logic        first_frame,
    input  logic [7:0]  penalty_index,
    input  logic signed [31:0] penalty_value,
    input  logic signed [23:0] local_score,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [15:0] frame_index,
    output logic signed [47:0] cumulative_score,
    output logic signed [16:0] back_link
);

    localparam int AW  = $clog2(MAX_GAP);
    localparam int GW  = $clog2(MAX_GAP + 1) + 1;
    localparam int FCW = $clog2(MAX_FRAMES + 1);
    localparam logic [AW-1:0] RING_LAST = AW'(MAX_GAP - 1);

    typedef enum logic [1:0] {IDLE, RUN, LAST, FINISH} state_t;

    bdf_pkg::bdf_cfg_t cfg;

    bdf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg;
    logic [FCW-1:0] fc_reg;
    logic [FCW-1:0] i_reg;
    logic [AW-1:0]  ptr_reg;
    logic [AW-1:0]  haddr_reg;
    logic [GW-1:0]  lo_reg;
    logic [GW-1:0]  gap_reg;
    logic [bdf_pkg::CNT_W-1:0] cnt_reg;
    logic [bdf_pkg::CNT_W-1:0] g_reg;
    logic signed [bdf_pkg::LOC_W-1:0] local_reg;
    logic st_valid_reg;
    logic st_first_reg;
    logic st_has_reg;
    logic [GW-1:0] st_gap_reg;
    logic signed [bdf_pkg::SUM_W-1:0] best_reg;
    logic [GW-1:0] best_gap_reg;
    logic result_valid_reg;
    logic [15:0] frame_index_reg;
    logic signed [47:0] cum_reg;
    logic signed [16:0] link_reg;

    logic [bdf_pkg::PEN_W-1:0] pen_mem [bdf_pkg::TABLE_DEPTH];
    logic [bdf_pkg::CUM_W-1:0] hist_mem [MAX_GAP];
    logic [bdf_pkg::PEN_W-1:0] pen_q_reg;
    logic [bdf_pkg::CUM_W-1:0] hist_q_reg;

    logic accept;
    logic load_wr;
    logic fin_load;
    logic restart;
    logic [FCW-1:0] i_c;
    logic [AW-1:0]  ptr_c;
    logic [GW-1:0]  lo_c;
    logic [bdf_pkg::CNT_W-1:0] cnt_c;
    logic signed [31:0] lim_c;
    logic signed [31:0] start_c;
    logic signed [bdf_pkg::SUM_W-1:0] sum_c;
    logic signed [bdf_pkg::ACC_W-1:0] acc_c;
    logic [bdf_pkg::CUM_W-1:0] cum_c;
    logic [31:0] i32_c;
    logic [31:0] gap32_c;
    logic [31:0] diff_c;
    logic [bdf_pkg::LINK_W-1:0] link_c;

    assign item_ready   = (state_reg == IDLE);
    assign accept       = item_valid && item_ready;
    assign load_wr      = accept && (op == bdf_pkg::OP_LOAD);
    assign fin_load     = (state_reg == FINISH) && (!result_valid_reg || result_ready);
    assign result_valid = result_valid_reg;
    assign frame_index      = frame_index_reg;
    assign cumulative_score = cum_reg;
    assign back_link        = link_reg;

    // clamp the gap range and locate the first history entry
    always_comb
    begin
        restart = first_frame || (32'(fc_reg) >= MAX_FRAMES);
        i_c     = restart ? '0 : fc_reg;
        ptr_c   = restart ? '0 : ptr_reg;
        if (cfg.min_gap == 8'd0)
            lo_c = GW'(1);
        else if (32'(cfg.min_gap) > MAX_GAP)
            lo_c = GW'(MAX_GAP);
        else
            lo_c = GW'(cfg.min_gap);
        cnt_c = (cfg.num_gaps > 9'(bdf_pkg::TABLE_DEPTH)) ?
                9'(bdf_pkg::TABLE_DEPTH) : cfg.num_gaps;
        lim_c = 32'(MAX_GAP) - 32'(lo_c) + 32'sd1;
        if ($signed(32'(cnt_c)) > lim_c)
            cnt_c = lim_c[bdf_pkg::CNT_W-1:0];
        if (cnt_c == '0)
            cnt_c = 9'd1;
        start_c = $signed(32'(ptr_c)) - $signed(32'(lo_c));
        if (start_c < 0)
            start_c = start_c + 32'(MAX_GAP);
    end

    always_comb
    begin
        sum_c = {{(bdf_pkg::SUM_W-bdf_pkg::PEN_W){pen_q_reg[bdf_pkg::PEN_W-1]}}, pen_q_reg};
        if (st_has_reg)
            sum_c = sum_c +
                {{(bdf_pkg::SUM_W-bdf_pkg::CUM_W){hist_q_reg[bdf_pkg::CUM_W-1]}}, hist_q_reg};
    end

    always_comb
    begin
        acc_c = {{(bdf_pkg::ACC_W-bdf_pkg::LOC_W){local_reg[bdf_pkg::LOC_W-1]}}, local_reg} +
                {{(bdf_pkg::ACC_W-bdf_pkg::SUM_W){best_reg[bdf_pkg::SUM_W-1]}}, best_reg};
        if (acc_c > bdf_pkg::ACC_HI)
            cum_c = bdf_pkg::CUM_HI;
        else if (acc_c < bdf_pkg::ACC_LO)
            cum_c = bdf_pkg::CUM_LO;
        else
            cum_c = acc_c[bdf_pkg::CUM_W-1:0];
        i32_c   = 32'(i_reg);
        gap32_c = 32'(best_gap_reg);
        diff_c  = i32_c - gap32_c;
        link_c  = (gap32_c <= i32_c) ? diff_c[bdf_pkg::LINK_W-1:0] : '1;
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
            pen_mem[penalty_index] <= penalty_value;
        pen_q_reg <= pen_mem[g_reg[bdf_pkg::TAB_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
            hist_mem[ptr_reg] <= cum_c;
        hist_q_reg <= hist_mem[haddr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            fc_reg           <= '0;
            ptr_reg          <= '0;
            st_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            i_reg            <= '0;
            haddr_reg        <= '0;
            lo_reg           <= '0;
            gap_reg          <= '0;
            cnt_reg          <= '0;
            g_reg            <= '0;
            local_reg        <= '0;
            st_first_reg     <= 1'b0;
            st_has_reg       <= 1'b0;
            st_gap_reg       <= '0;
            best_reg         <= '0;
            best_gap_reg     <= '0;
            frame_index_reg  <= '0;
            cum_reg          <= '0;
            link_reg         <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && !fin_load)
                result_valid_reg <= 1'b0;

            // compare stage: first maximum wins
            if (st_valid_reg && (st_first_reg || sum_c > best_reg))
            begin
                best_reg     <= sum_c;
                best_gap_reg <= st_gap_reg;
            end

            st_valid_reg <= (state_reg == RUN);

            case (state_reg)
                IDLE:
                begin
                    if (accept && op == bdf_pkg::OP_SCORE)
                    begin
                        i_reg     <= i_c;
                        ptr_reg   <= ptr_c;
                        lo_reg    <= lo_c;
                        gap_reg   <= lo_c;
                        cnt_reg   <= cnt_c;
                        g_reg     <= '0;
                        haddr_reg <= start_c[AW-1:0];
                        local_reg <= local_score;
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    st_first_reg <= (g_reg == '0);
                    st_has_reg   <= (32'(gap_reg) <= 32'(i_reg));
                    st_gap_reg   <= gap_reg;
                    g_reg        <= g_reg + 1'b1;
                    gap_reg      <= gap_reg + 1'b1;
                    haddr_reg    <= (haddr_reg == '0) ? RING_LAST : haddr_reg - 1'b1;
                    if (g_reg == cnt_reg - 1'b1)
                        state_reg <= LAST;
                end
                LAST:
                begin
                    state_reg <= FINISH;
                end
                FINISH:
                begin
                    if (fin_load)
                    begin
                        result_valid_reg <= 1'b1;
                        frame_index_reg  <= i32_c[bdf_pkg::FIDX_W-1:0];
                        cum_reg          <= cum_c;
                        link_reg         <= link_c;
                        fc_reg           <= i_reg + 1'b1;
                        ptr_reg          <= (ptr_reg == RING_LAST) ? '0 : ptr_reg + 1'b1;
                        state_reg        <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_stage_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        st_valid_reg |-> $past(state_reg == RUN))
        else $error("compare stage loaded outside the gap sweep");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == FINISH))
        else $error("result raised outside the finishing step");

    a_gap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN) |-> (g_reg < cnt_reg) && (32'(gap_reg) <= MAX_GAP))
        else $error("gap sweep ran past its clamped range");

    a_gap_tracks_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == RUN) |-> (32'(gap_reg) == 32'(lo_reg) + 32'(g_reg)))
        else $error("gap and table index out of step");

endmodule

// ===== sim/beat_dp_forward_pass_test.sv =====
// Self-checking testbench for beat_dp_forward_pass: penalty loads, score frames, register sweeps.
// Predicts each frame's cumulative score and back-link and compares every result in order.
// Depends on bdf_pkg and the beat_dp_forward_pass RTL.

module beat_dp_forward_pass_test;

    localparam int     MAX_GAP       = 256;
    localparam int     MAX_FRAMES    = 65536;
    localparam int     LOAD_SETTLE   = 4;
    localparam int     END_SETTLE    = 300;
    localparam int     MAX_PRINTED   = 100;
    localparam longint CUM_TOP       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint CUM_BOTTOM    = -CUM_TOP - 1;

    typedef struct packed {
        logic [15:0] fidx;
        logic [47:0] cum;
        logic [16:0] link;
    } frame_result_t;

    class beat_score_check;
        logic signed [47:0] score_ring [MAX_GAP];
        logic signed [31:0] pen_table [bdf_pkg::TABLE_DEPTH];
        int unsigned        next_frame;
        logic [7:0]         min_gap;
        logic [8:0]         num_gaps;
        frame_result_t      expected_frames [$];
        int                 errors;

        function new();
            next_frame = 0;
            min_gap    = bdf_pkg::MIN_GAP_RESET;
            num_gaps   = bdf_pkg::NUM_GAPS_RESET;
            errors     = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == bdf_pkg::REG_MIN_GAP)
                min_gap = val[7:0];
            else
                num_gaps = val[8:0];
        endfunction

        function void note_item(logic op_v, logic ff, logic [7:0] idx,
                                logic signed [31:0] pv, logic signed [23:0] ls);
            int unsigned   lo, cnt, lim, fr, g, best_g, gap;
            longint        best, s, cum;
            frame_result_t r;
            if (op_v == bdf_pkg::OP_LOAD)
            begin
                pen_table[idx] = pv;
                return;
            end
            if (ff || next_frame >= MAX_FRAMES)
                next_frame = 0;
            fr = next_frame;
            lo = (min_gap == 0) ? 1 : min_gap;
            if (lo > MAX_GAP)
                lo = MAX_GAP;
            cnt = num_gaps;
            if (cnt > bdf_pkg::TABLE_DEPTH)
                cnt = bdf_pkg::TABLE_DEPTH;
            lim = MAX_GAP - lo + 1;
            if (cnt > lim)
                cnt = lim;
            if (cnt < 1)
                cnt = 1;
            best   = 0;
            best_g = 0;
            for (g = 0; g < cnt; g++)
            begin
                gap = lo + g;
                s   = pen_table[g];
                if (gap <= fr)
                    s += score_ring[(fr - gap) % MAX_GAP];
                if (g == 0 || s > best)
                begin
                    best   = s;
                    best_g = g;
                end
            end
            cum = ls + best;
            if (cum > CUM_TOP)
                cum = CUM_TOP;
            if (cum < CUM_BOTTOM)
                cum = CUM_BOTTOM;
            score_ring[fr % MAX_GAP] = cum[47:0];
            r.fidx = fr[15:0];
            r.cum  = cum[47:0];
            r.link = (lo + best_g <= fr) ? 17'(fr - lo - best_g) : '1;
            expected_frames.insert(expected_frames.size(), r);
            next_frame = fr + 1;
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        endtask

        task check_result(logic [15:0] fi, logic [47:0] cs, logic [16:0] bl);
            frame_result_t e;
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result, frame_index", fi, 0);
                return;
            end
            e = expected_frames.pop_front();
            if (fi !== e.fidx)
                report_mismatch("frame_index", fi, e.fidx);
            if (cs !== e.cum)
                report_mismatch("cumulative_score", cs, e.cum);
            if (bl !== e.link)
                report_mismatch("back_link", bl, e.link);
        endtask

        function int pending();
            return expected_frames.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                item_valid;
    logic                item_ready;
    logic                op;
    logic                first_frame;
    logic [7:0]          penalty_index;
    logic signed [31:0]  penalty_value;
    logic signed [23:0]  local_score;
    logic                result_valid;
    logic                result_ready;
    logic [15:0]         frame_index;
    logic signed [47:0]  cumulative_score;
    logic signed [16:0]  back_link;

    beat_score_check sb;
    bit              loaded [bdf_pkg::TABLE_DEPTH];
    int              send_idle;
    int              recv_idle;

    beat_dp_forward_pass #(
        .MAX_GAP    (MAX_GAP),
        .MAX_FRAMES (MAX_FRAMES)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .op               (op),
        .first_frame      (first_frame),
        .penalty_index    (penalty_index),
        .penalty_value    (penalty_value),
        .local_score      (local_score),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .frame_index      (frame_index),
        .cumulative_score (cumulative_score),
        .back_link        (back_link)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(frame_index, cumulative_score, back_link);
        result_ready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic logic signed [31:0] rand_penalty();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return -32'($urandom_range(1 << 20));
            default: return {1'b1, 31'($urandom())};
        endcase
    endfunction

    function automatic logic signed [23:0] rand_local();
        case ($urandom_range(3))
            0:       return 24'sh7F_FFFF;
            1:       return 24'sh80_0000;
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic send_item(logic op_v, logic ff, logic [7:0] idx,
                             logic signed [31:0] pv, logic signed [23:0] ls);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        op            <= op_v;
        first_frame   <= ff;
        penalty_index <= idx;
        penalty_value <= pv;
        local_score   <= ls;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (op_v == bdf_pkg::OP_LOAD)
            loaded[idx] = 1'b1;
        sb.note_item(op_v, ff, idx, pv, ls);
    endtask

    task automatic load_entry(logic [7:0] idx, logic signed [31:0] pv);
        send_item(bdf_pkg::OP_LOAD, 1'($urandom()), idx, pv, 24'($urandom()));
    endtask

    task automatic score_frame(logic ff, logic signed [23:0] ls);
        send_item(bdf_pkg::OP_SCORE, ff, 8'($urandom()), 32'($urandom()), ls);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic configure(logic [7:0] mg, logic [8:0] gc);
        int unsigned lo, cnt, i;
        logic [31:0] word;
        drain();
        repeat (LOAD_SETTLE) @(posedge clk);
        word       = $urandom();
        word[7:0]  = mg;
        apb_write(bdf_pkg::REG_MIN_GAP, word);
        word       = $urandom();
        word[8:0]  = gc;
        apb_write(bdf_pkg::REG_NUM_GAPS, word);
        lo  = (mg == 0) ? 1 : mg;
        cnt = (gc > bdf_pkg::TABLE_DEPTH) ? bdf_pkg::TABLE_DEPTH : gc;
        if (cnt > MAX_GAP - lo + 1)
            cnt = MAX_GAP - lo + 1;
        if (cnt < 1)
            cnt = 1;
        for (i = 0; i < cnt; i++)
            if (!loaded[i])
                load_entry(8'(i), rand_penalty());
    endtask

    task automatic run_phase(int n, int ff_odds);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(59) == 0)
                drain();
            if ($urandom_range(99) < 15)
                load_entry(8'($urandom()), rand_penalty());
            else
                score_frame($urandom_range(ff_odds - 1) == 0, rand_local());
        end
    endtask

    initial
    begin
        int k;
        sb            = new();
        send_idle     = 8;
        recv_idle     = 83;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        item_valid    <= 1'b0;
        op            <= bdf_pkg::OP_LOAD;
        first_frame   <= 1'b0;
        penalty_index <= '0;
        penalty_value <= '0;
        local_score   <= '0;
        result_ready  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values, ties at frame zero, field extremes, restart
        load_entry(8'd0, 32'sd0);
        load_entry(8'd1, 32'sd0);
        load_entry(8'd255, 32'sh8000_0000);
        score_frame(1'b1, 24'sh7F_FFFF);
        score_frame(1'b0, 24'sh80_0000);
        score_frame(1'b0, 24'sd0);
        load_entry(8'd1, 32'sh8000_0000);
        score_frame(1'b0, 24'sh7F_FFFF);
        score_frame(1'b0, 24'sh80_0000);
        load_entry(8'd0, -32'sd1);
        score_frame(1'b1, 24'sd1);
        score_frame(1'b0, -24'sd1);
        score_frame(1'b0, 24'sh7F_FFFF);
        load_entry(8'd2, 32'sd0);
        load_entry(8'd3, -32'sd65536);

        configure(8'd0, 9'd0);
        run_phase(15, 10);
        configure(8'd3, 9'd4);
        run_phase(20, 40);

        // one long sequence across the ring wrap, then the widest gaps
        send_idle = 83;
        recv_idle = 8;
        configure(8'd1, 9'd128);
        run_phase(220, 1000000);
        configure(8'd255, 9'd511);
        run_phase(90, 1000000);

        send_idle = 0;
        recv_idle = 0;
        configure(8'd7, 9'd40);
        run_phase(20, 40);
        configure(8'd128, 9'd200);
        run_phase(20, 40);

        // short closing sequence at the strongest penalty
        configure(8'd1, 9'd1);
        load_entry(8'd0, 32'sh8000_0000);
        score_frame(1'b1, 24'sh80_0000);
        for (k = 0; k < 12; k++)
            score_frame(1'b0, ($urandom_range(3) == 0) ? rand_local() : 24'sh80_0000);

        drain();
        repeat (END_SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/bdf_pkg.sv
design/bdf_regs.sv
design/beat_dp_forward_pass.sv
sim/beat_dp_forward_pass_test.sv
